// File: rtl/core/sap_pkg.sv
`default_nettype none

package sap_pkg;

   // angle accumulator: degrees with 16 fractional bits, sign and headroom
   localparam int ANG_FRAC = 16;
   localparam int ANGLE_W  = 26;
   localparam int OUT_W    = 9;

   localparam logic signed [ANGLE_W-1:0] Z_QUARTER = ANGLE_W'(90 * 65536);

   localparam logic signed [OUT_W-1:0] DEG_HALF_TURN = OUT_W'(180);
   localparam logic signed [OUT_W-1:0] DEG_QUARTER   = OUT_W'(90);
   localparam logic signed [OUT_W-1:0] DEG_SAT       = OUT_W'(179);

   // results decided before the CORDIC ride along beside it
   typedef struct packed {
      logic                    special;
      logic signed [OUT_W-1:0] angle;
      logic                    zero_vector;
   } side_type;

   // atan(2^-i) in degrees, Q16, rounded to nearest
   function automatic logic signed [ANGLE_W-1:0] atan_deg_q16(input logic [4:0] idx);
      logic signed [ANGLE_W-1:0] val;
      case (idx)
         5'd0:    val = ANGLE_W'(2949120);
         5'd1:    val = ANGLE_W'(1740967);
         5'd2:    val = ANGLE_W'(919879);
         5'd3:    val = ANGLE_W'(466945);
         5'd4:    val = ANGLE_W'(234379);
         5'd5:    val = ANGLE_W'(117304);
         5'd6:    val = ANGLE_W'(58666);
         5'd7:    val = ANGLE_W'(29335);
         5'd8:    val = ANGLE_W'(14668);
         5'd9:    val = ANGLE_W'(7334);
         5'd10:   val = ANGLE_W'(3667);
         5'd11:   val = ANGLE_W'(1833);
         5'd12:   val = ANGLE_W'(917);
         5'd13:   val = ANGLE_W'(458);
         5'd14:   val = ANGLE_W'(229);
         5'd15:   val = ANGLE_W'(115);
         5'd16:   val = ANGLE_W'(57);
         5'd17:   val = ANGLE_W'(29);
         5'd18:   val = ANGLE_W'(14);
         5'd19:   val = ANGLE_W'(7);
         5'd20:   val = ANGLE_W'(4);
         5'd21:   val = ANGLE_W'(2);
         5'd22:   val = ANGLE_W'(1);
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/sap_if.sv
`default_nettype none

interface sap_req_if #(parameter int COORD_BITS = 16);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] vertex_x;
   logic signed [COORD_BITS-1:0] vertex_y;
   logic signed [COORD_BITS-1:0] first_x;
   logic signed [COORD_BITS-1:0] first_y;
   logic signed [COORD_BITS-1:0] second_x;
   logic signed [COORD_BITS-1:0] second_y;

   modport source (output valid, vertex_x, vertex_y, first_x, first_y, second_x, second_y,
                   input ready);
   modport sink   (input valid, vertex_x, vertex_y, first_x, first_y, second_x, second_y,
                   output ready);
endinterface

interface sap_rsp_if;
   logic                            valid;
   logic                            ready;
   logic signed [sap_pkg::OUT_W-1:0] angle_degrees;
   logic                            zero_vector;

   modport source (output valid, angle_degrees, zero_vector, input ready);
   modport sink   (input valid, angle_degrees, zero_vector, output ready);
endinterface

`default_nettype wire

// File: rtl/core/sap_front.sv
`default_nettype none

// Four stages: differences, products, cross/dot, classify and pre-rotate.
module sap_front #(
   parameter int COORD_BITS = 16
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    in_valid,
   output logic                                         in_ready,
   input  wire logic signed [COORD_BITS-1:0]            vertex_x,
   input  wire logic signed [COORD_BITS-1:0]            vertex_y,
   input  wire logic signed [COORD_BITS-1:0]            first_x,
   input  wire logic signed [COORD_BITS-1:0]            first_y,
   input  wire logic signed [COORD_BITS-1:0]            second_x,
   input  wire logic signed [COORD_BITS-1:0]            second_y,
   output logic                                         out_valid,
   input  wire logic                                    out_ready,
   output logic signed [2*COORD_BITS+5:0]               out_x,
   output logic signed [2*COORD_BITS+5:0]               out_y,
   output logic signed [sap_pkg::ANGLE_W-1:0]           out_z,
   output sap_pkg::side_type                            out_side
);

   localparam int DW = COORD_BITS + 1;
   localparam int PW = 2 * DW;
   localparam int XW = PW + 1;
   localparam int CW = 2 * COORD_BITS + 6;

   logic va_ff, vb_ff, vc_ff, vd_ff;
   logic rdy_a, rdy_b, rdy_c, rdy_d;

   logic signed [DW-1:0] ax_ff, ay_ff, bx_ff, by_ff;
   logic signed [DW-1:0] ax_in, ay_in, bx_in, by_in;
   logic signed [PW-1:0] p0_ff, p1_ff, p2_ff, p3_ff;
   logic signed [PW-1:0] p0_in, p1_in, p2_in, p3_in;
   logic                 zb_ff, zc_ff, zb_in;
   logic signed [XW-1:0] cross_ff, dot_ff, cross_in, dot_in;
   logic signed [CW-1:0] x_ff, y_ff, x_in, y_in;
   logic signed [sap_pkg::ANGLE_W-1:0] z_ff, z_in;
   sap_pkg::side_type    side_ff, side_in;

   assign rdy_d    = !vd_ff || out_ready;
   assign rdy_c    = !vc_ff || rdy_d;
   assign rdy_b    = !vb_ff || rdy_c;
   assign rdy_a    = !va_ff || rdy_b;
   assign in_ready = rdy_a;

   assign ax_in = DW'(first_x)  - DW'(vertex_x);
   assign ay_in = DW'(first_y)  - DW'(vertex_y);
   assign bx_in = DW'(second_x) - DW'(vertex_x);
   assign by_in = DW'(second_y) - DW'(vertex_y);

   assign p0_in = PW'(ax_ff) * PW'(by_ff);
   assign p1_in = PW'(ay_ff) * PW'(bx_ff);
   assign p2_in = PW'(ax_ff) * PW'(bx_ff);
   assign p3_in = PW'(ay_ff) * PW'(by_ff);
   assign zb_in = (ax_ff == '0 && ay_ff == '0) || (bx_ff == '0 && by_ff == '0);

   assign cross_in = XW'(p0_ff) - XW'(p1_ff);
   assign dot_in   = XW'(p2_ff) + XW'(p3_ff);

   always_comb begin
      x_in = CW'(dot_ff);
      y_in = CW'(cross_ff);
      z_in = '0;
      if (dot_ff < 0) begin
         if (cross_ff >= 0) begin
            x_in = CW'(cross_ff);
            y_in = -CW'(dot_ff);
            z_in = sap_pkg::Z_QUARTER;
         end else begin
            x_in = -CW'(cross_ff);
            y_in = CW'(dot_ff);
            z_in = -sap_pkg::Z_QUARTER;
         end
      end
      side_in.special     = 1'b1;
      side_in.zero_vector = 1'b0;
      side_in.angle       = '0;
      if (zc_ff) begin
         side_in.zero_vector = 1'b1;
      end else if (cross_ff == '0) begin
         side_in.angle = (dot_ff > 0) ? '0 : sap_pkg::DEG_HALF_TURN;
      end else if (dot_ff == '0) begin
         side_in.angle = (cross_ff > 0) ? sap_pkg::DEG_QUARTER : -sap_pkg::DEG_QUARTER;
      end else begin
         side_in.special = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
      end else begin
         if (rdy_a) va_ff <= in_valid;
         if (rdy_b) vb_ff <= va_ff;
         if (rdy_c) vc_ff <= vb_ff;
         if (rdy_d) vd_ff <= vc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_a && in_valid) begin
         ax_ff <= ax_in;
         ay_ff <= ay_in;
         bx_ff <= bx_in;
         by_ff <= by_in;
      end
      if (rdy_b && va_ff) begin
         p0_ff <= p0_in;
         p1_ff <= p1_in;
         p2_ff <= p2_in;
         p3_ff <= p3_in;
         zb_ff <= zb_in;
      end
      if (rdy_c && vb_ff) begin
         cross_ff <= cross_in;
         dot_ff   <= dot_in;
         zc_ff    <= zb_ff;
      end
      if (rdy_d && vc_ff) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         side_ff <= side_in;
      end
   end

   assign out_valid = vd_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;
   assign out_side  = side_ff;

endmodule

`default_nettype wire

// File: rtl/core/sap_cordic_stage.sv
`default_nettype none

// One vectoring micro-rotation, registered.
module sap_cordic_stage #(
   parameter int COORD_BITS = 16,
   parameter int STEP       = 0
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              in_valid,
   output logic                                   in_ready,
   input  wire logic signed [2*COORD_BITS+5:0]    in_x,
   input  wire logic signed [2*COORD_BITS+5:0]    in_y,
   input  wire logic signed [sap_pkg::ANGLE_W-1:0] in_z,
   input  wire sap_pkg::side_type                 in_side,
   output logic                                   out_valid,
   input  wire logic                              out_ready,
   output logic signed [2*COORD_BITS+5:0]         out_x,
   output logic signed [2*COORD_BITS+5:0]         out_y,
   output logic signed [sap_pkg::ANGLE_W-1:0]     out_z,
   output sap_pkg::side_type                      out_side
);

   localparam int CW = 2 * COORD_BITS + 6;
   localparam logic signed [sap_pkg::ANGLE_W-1:0] ATAN = sap_pkg::atan_deg_q16(5'(STEP));

   logic                 v_ff;
   logic signed [CW-1:0] x_ff, y_ff, x_in, y_in, xs, ys;
   logic signed [sap_pkg::ANGLE_W-1:0] z_ff, z_in;
   sap_pkg::side_type    side_ff;

   assign in_ready = !v_ff || out_ready;

   assign xs = in_x >>> STEP;
   assign ys = in_y >>> STEP;

   always_comb begin
      if (!in_y[CW-1] && in_y != '0) begin
         x_in = in_x + ys;
         y_in = in_y - xs;
         z_in = in_z + ATAN;
      end else begin
         x_in = in_x - ys;
         y_in = in_y + xs;
         z_in = in_z - ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (in_ready) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = v_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;
   assign out_side  = side_ff;

endmodule

`default_nettype wire

// File: rtl/core/sap_back.sv
`default_nettype none

// Truncate to whole degrees, saturate, merge early results; output register.
module sap_back (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               in_valid,
   output logic                                    in_ready,
   input  wire logic signed [sap_pkg::ANGLE_W-1:0] in_z,
   input  wire sap_pkg::side_type                  in_side,
   output logic                                    out_valid,
   input  wire logic                               out_ready,
   output logic signed [sap_pkg::OUT_W-1:0]        out_angle,
   output logic                                    out_zero
);

   localparam int ZW = sap_pkg::ANGLE_W;

   logic                             v_ff;
   logic signed [ZW-1:0]             whole, neg_z;
   logic signed [sap_pkg::OUT_W-1:0] angle_ff, angle_in;
   logic                             zero_ff;

   assign in_ready = !v_ff || out_ready;
   assign neg_z    = -in_z;

   always_comb begin
      if (!in_z[ZW-1]) begin
         whole = in_z >>> sap_pkg::ANG_FRAC;
      end else begin
         whole = -(neg_z >>> sap_pkg::ANG_FRAC);
      end
      if (in_side.special) begin
         angle_in = in_side.angle;
      end else if (whole > ZW'(sap_pkg::DEG_SAT)) begin
         angle_in = sap_pkg::DEG_SAT;
      end else if (whole < -ZW'(sap_pkg::DEG_SAT)) begin
         angle_in = -sap_pkg::DEG_SAT;
      end else begin
         angle_in = whole[sap_pkg::OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (in_ready) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         angle_ff <= angle_in;
         zero_ff  <= in_side.zero_vector;
      end
   end

   assign out_valid = v_ff;
   assign out_angle = angle_ff;
   assign out_zero  = zero_ff;

endmodule

`default_nettype wire

// File: rtl/core/signed_angle_three_points_deg_top.sv
`default_nettype none

// channel | dir | moves                                  | handshake
// req_ch  | in  | vertex, first end, second end (x, y)   | valid/ready
// rsp_ch  | out | angle_degrees (signed), zero_vector    | valid/ready
//
// One request per cycle, sustained while rsp_ch accepts responses. Stages:
// four front stages, one stage per CORDIC iteration, one output stage.
// Synchronous active-high reset clears only the valid bits.
// Each stage holds its request while the stage ahead cannot take it, so a stall
// on rsp_ch backs up stage by stage and bubbles are squeezed out.
module signed_angle_three_points_deg_top #(
   parameter int COORD_BITS   = 16,
   parameter int CORDIC_STEPS = 24
) (
   input  wire logic  clock,
   input  wire logic  reset,
   sap_req_if.sink    req_ch,
   sap_rsp_if.source  rsp_ch
);

   // x/y carry cross and dot (2*COORD_BITS+3 bits) plus CORDIC gain headroom
   localparam int CW = 2 * COORD_BITS + 6;

   logic                               valid_w [CORDIC_STEPS+1];
   logic                               ready_w [CORDIC_STEPS+1];
   logic signed [CW-1:0]               x_w     [CORDIC_STEPS+1];
   logic signed [CW-1:0]               y_w     [CORDIC_STEPS+1];
   logic signed [sap_pkg::ANGLE_W-1:0] z_w     [CORDIC_STEPS+1];
   sap_pkg::side_type                  side_w  [CORDIC_STEPS+1];

   // differences, products, cross/dot, half-plane fold and early results
   sap_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .vertex_x  (req_ch.vertex_x),
      .vertex_y  (req_ch.vertex_y),
      .first_x   (req_ch.first_x),
      .first_y   (req_ch.first_y),
      .second_x  (req_ch.second_x),
      .second_y  (req_ch.second_y),
      .out_valid (valid_w[0]),
      .out_ready (ready_w[0]),
      .out_x     (x_w[0]),
      .out_y     (y_w[0]),
      .out_z     (z_w[0]),
      .out_side  (side_w[0])
   );

   // vectoring CORDIC, one iteration per stage; y is driven toward zero
   for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_step
      sap_cordic_stage #(
         .COORD_BITS (COORD_BITS),
         .STEP       (g)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid_w[g]),
         .in_ready  (ready_w[g]),
         .in_x      (x_w[g]),
         .in_y      (y_w[g]),
         .in_z      (z_w[g]),
         .in_side   (side_w[g]),
         .out_valid (valid_w[g+1]),
         .out_ready (ready_w[g+1]),
         .out_x     (x_w[g+1]),
         .out_y     (y_w[g+1]),
         .out_z     (z_w[g+1]),
         .out_side  (side_w[g+1])
      );
   end

   // whole degrees toward zero, clamp CORDIC results to +/-179, output register
   sap_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid_w[CORDIC_STEPS]),
      .in_ready  (ready_w[CORDIC_STEPS]),
      .in_z      (z_w[CORDIC_STEPS]),
      .in_side   (side_w[CORDIC_STEPS]),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_angle (rsp_ch.angle_degrees),
      .out_zero  (rsp_ch.zero_vector)
   );

endmodule

`default_nettype wire
